[rtl/si_pkg.sv]
// Shared constants for the segment intersection block.
// No dependencies; used by every module of the block.
package si_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned NUM_FIELDS  = 8;
  localparam int unsigned IN_TDATA_W  = FIELD_W * NUM_FIELDS;
  localparam int unsigned PARAM_W     = 16;
  localparam int unsigned OUT_TDATA_W = 24;

endpackage

[rtl/segment_intersection.sv]
// Segment intersection top level: front pipeline plus a row of divider cells.
// Depends on si_pkg, si_front and si_div_cell.
//
// Usage:
//   Slave stream carries one segment pair per beat; tdata holds eight signed
//   16-bit coordinates. Master stream returns one beat per pair with the hit
//   flag and the floored crossing parameter along the first segment.
//   The pipe has four front stages (differences, products, determinant,
//   interval test) then one cell per fraction bit.
//   Throughput is one pair per cycle while tready stays high; every stage holds
//   one beat and a stage takes a new beat whenever it is empty or its
//   successor takes its beat, so gaps in the pipe close up while the receiver stalls.
//   When the receiver holds tready low the pipe fills and s_axis_tready
//   drops only once every stage holds a beat.
//   Reset clears all stage valids; no pending beat survives it. There is no
//   state carried between pairs.
module segment_intersection
  import si_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit [0], param_a [16:1], zero pad [23:17]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned NW = 2 * COORD_BITS + 3;

  logic               lv [FRAC_BITS+1];
  logic               lr [FRAC_BITS+1];
  logic               lh [FRAC_BITS+1];
  logic [NW-1:0]      lrem [FRAC_BITS+1];
  logic [NW-1:0]      lden [FRAC_BITS+1];
  logic [PARAM_W-1:0] lquo [FRAC_BITS+1];

  si_front #(
    .COORD_BITS (COORD_BITS),
    .NW         (NW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .tdata_i (s_axis_tdata),
    .valid_o (lv[0]),
    .ready_i (lr[0]),
    .hit_o   (lh[0]),
    .rem_o   (lrem[0]),
    .den_o   (lden[0])
  );

  assign lquo[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    si_div_cell #(
      .NW (NW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lv[i]),
      .ready_o (lr[i]),
      .hit_i   (lh[i]),
      .rem_i   (lrem[i]),
      .den_i   (lden[i]),
      .quo_i   (lquo[i]),
      .valid_o (lv[i+1]),
      .ready_i (lr[i+1]),
      .hit_o   (lh[i+1]),
      .rem_o   (lrem[i+1]),
      .den_o   (lden[i+1]),
      .quo_o   (lquo[i+1])
    );
  end

  assign lr[FRAC_BITS] = m_axis_tready;
  assign m_axis_tvalid = lv[FRAC_BITS];
  assign m_axis_tdata  = {(OUT_TDATA_W - PARAM_W - 1)'(0), lquo[FRAC_BITS], lh[FRAC_BITS]};

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == '0)
    else $error("miss beat carries a nonzero parameter");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lv[0] && lh[0] |-> lrem[0] < lden[0])
    else $error("front remainder not below divisor on a hit");

  a_miss_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lv[0] && !lh[0] |-> lrem[0] == '0 && lden[0] == NW'(1))
    else $error("miss does not feed zero over one to the cells");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lv[FRAC_BITS] && !m_axis_tready |=> lv[FRAC_BITS] && $stable(lquo[FRAC_BITS]))
    else $error("last cell lost its beat under stall");
`endif

endmodule

[rtl/si_front.sv]
// Front pipeline: coordinate differences, products, determinant and
// numerators, then the open-interval test. Feeds the divider cell row.
// Depends on si_pkg.
module si_front
  import si_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned NW         = 2 * COORD_BITS + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [IN_TDATA_W-1:0] tdata_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic                  hit_o,
  output logic [NW-1:0]         rem_o,
  output logic [NW-1:0]         den_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [CW-1:0] coord [NUM_FIELDS];

  for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_coord
    if (COORD_BITS <= FIELD_W) begin : g_narrow
      assign coord[k] = tdata_i[k*FIELD_W +: COORD_BITS];
    end else begin : g_wide
      assign coord[k] = CW'(tdata_i[k*FIELD_W +: FIELD_W]);
    end
  end

  // stage valids and ready chain
  logic v0_q, v1_q, v2_q, v3_q;
  logic r0, r1, r2, r3;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign r0      = !v0_q || r1;
  assign ready_o = r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r0) v0_q <= valid_i;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // stage 0: differences
  logic signed [DW-1:0] dax_q, day_q, nbx_q, nby_q, rx_q, ry_q;

  always_ff @(posedge clk_i) begin
    if (r0 && valid_i) begin
      dax_q <= DW'(coord[2]) - DW'(coord[0]);
      day_q <= DW'(coord[3]) - DW'(coord[1]);
      nbx_q <= DW'(coord[4]) - DW'(coord[6]);
      nby_q <= DW'(coord[5]) - DW'(coord[7]);
      rx_q  <= DW'(coord[4]) - DW'(coord[0]);
      ry_q  <= DW'(coord[5]) - DW'(coord[1]);
    end
  end

  // stage 1: products
  logic signed [PW-1:0] p_det0_q, p_det1_q, p_ns0_q, p_ns1_q, p_nt0_q, p_nt1_q;

  always_ff @(posedge clk_i) begin
    if (r1 && v0_q) begin
      p_det0_q <= dax_q * nby_q;
      p_det1_q <= nbx_q * day_q;
      p_ns0_q  <= nby_q * rx_q;
      p_ns1_q  <= nbx_q * ry_q;
      p_nt0_q  <= dax_q * ry_q;
      p_nt1_q  <= day_q * rx_q;
    end
  end

  // stage 2: determinant and Cramer numerators
  logic signed [NW-1:0] det_q, ns_q, nt_q;

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      det_q <= NW'(p_det0_q) - NW'(p_det1_q);
      ns_q  <= NW'(p_ns0_q) - NW'(p_ns1_q);
      nt_q  <= NW'(p_nt0_q) - NW'(p_nt1_q);
    end
  end

  // stage 3: open-interval test, magnitudes
  logic          det_pos, det_nz, s_in, t_in, hit_d;
  logic [NW-1:0] ns_mag, det_mag;
  logic          hit_q;
  logic [NW-1:0] rem_q, den_q;

  always_comb begin
    det_pos = !det_q[NW-1] && (det_q != '0);
    det_nz  = (det_q != '0);
    if (det_pos) begin
      s_in = (ns_q > 0) && (ns_q < det_q);
      t_in = (nt_q > 0) && (nt_q < det_q);
    end else begin
      s_in = (ns_q < 0) && (ns_q > det_q);
      t_in = (nt_q < 0) && (nt_q > det_q);
    end
    hit_d   = det_nz && s_in && t_in;
    ns_mag  = ns_q[NW-1]  ? NW'(-ns_q)  : NW'(ns_q);
    det_mag = det_q[NW-1] ? NW'(-det_q) : NW'(det_q);
  end

  // a miss divides zero by one so the quotient comes out zero
  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      hit_q <= hit_d;
      rem_q <= hit_d ? ns_mag : '0;
      den_q <= hit_d ? det_mag : NW'(1);
    end
  end

  assign valid_o = v3_q;
  assign hit_o   = hit_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;

endmodule

[rtl/si_div_cell.sv]
// One restoring-division step: yields one fraction bit and the partial
// remainder for the next cell. Depends on si_pkg.
module si_div_cell
  import si_pkg::*;
#(
  parameter int unsigned NW = 2 * COORD_BITS_DEF + 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               hit_i,
  input  logic [NW-1:0]      rem_i,
  input  logic [NW-1:0]      den_i,
  input  logic [PARAM_W-1:0] quo_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic               hit_o,
  output logic [NW-1:0]      rem_o,
  output logic [NW-1:0]      den_o,
  output logic [PARAM_W-1:0] quo_o
);

  logic               valid_q;
  logic               hit_q;
  logic [NW-1:0]      rem_q, den_q, rem_d, rem2;
  logic [PARAM_W-1:0] quo_q, quo_d;
  logic               bit_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rem2  = {rem_i[NW-2:0], 1'b0};
    bit_d = (rem2 >= den_i);
    rem_d = bit_d ? rem2 - den_i : rem2;
    quo_d = {quo_i[PARAM_W-2:0], bit_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hit_q <= hit_i;
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;

endmodule
